@@ rtl/ssbt_pkg.sv @@
package ssbt_pkg;

    localparam logic [31:0] STATE_UNKNOWN = 32'hFFFF_FFFF;
    localparam int          SUB_LIMIT     = 16;
    localparam logic [4:0]  COUNT_RESET   = 5'd16;

    localparam logic KIND_IMMEDIATE = 1'b0;
    localparam logic KIND_PENDING   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FLUSH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch request, set scan index and end
        logic restart;     // scan index back to zero
        logic inc;         // next entry
        logic hold_entry;  // push out held record, hold record for current entry
        logic hold_all;    // hold one all-subresources record, write every entry in use
        logic flush;       // push out held record as the final one
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_all;
        logic count_zero;
        logic index_in_range;
        logic cur_eq_want;
        logic cur_breaks_uniform;
        logic first_eq_want;
        logic at_end;
    } t_status;

endpackage

@@ rtl/ssbt_ctrl.sv @@
module ssbt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ssbt_pkg::t_status i_status,
    output ssbt_pkg::t_cmd    o_cmd
);
    import ssbt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_status.req_all) begin
                        n_state = i_status.count_zero ? ST_IDLE : ST_CHECK;
                    end else begin
                        n_state = i_status.index_in_range ? ST_WALK : ST_IDLE;
                    end
                end
            end
            ST_CHECK: begin
                if (i_status.cur_breaks_uniform) begin
                    n_state = ST_WALK;
                end else if (i_status.at_end) begin
                    n_state = i_status.first_eq_want ? ST_IDLE : ST_FLUSH;
                end
            end
            ST_WALK: begin
                if (i_status.at_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = start;
            end
            ST_CHECK: begin
                if (i_status.cur_breaks_uniform) begin
                    o_cmd.restart = 1'b1;
                end else if (i_status.at_end) begin
                    o_cmd.hold_all = !i_status.first_eq_want;
                end else begin
                    o_cmd.inc = 1'b1;
                end
            end
            ST_WALK: begin
                o_cmd.hold_entry = !i_status.cur_eq_want;
                o_cmd.inc        = !i_status.at_end;
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

@@ rtl/ssbt_datapath.sv @@
module ssbt_datapath #(
    parameter int MAX_SUBRESOURCES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [4:0]        i_cfg_data,
    input  logic [31:0]       i_desired_state,
    input  logic              i_all_subresources,
    input  logic [3:0]        i_subresource_index,
    input  ssbt_pkg::t_cmd    i_cmd,
    output ssbt_pkg::t_status o_status,
    output logic              o_strobe,
    output logic              o_record_kind,
    output logic              o_covers_all,
    output logic [3:0]        o_barrier_subresource,
    output logic [31:0]       o_state_before,
    output logic [31:0]       o_state_after,
    output logic              o_last_record
);
    import ssbt_pkg::*;

    // entries past the index field's reach are never addressed
    localparam int DEPTH = (MAX_SUBRESOURCES < SUB_LIMIT) ? MAX_SUBRESOURCES : SUB_LIMIT;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] r_tab [DEPTH];
    logic [4:0]  r_count;
    logic [31:0] r_want;
    logic [3:0]  r_idx;
    logic [3:0]  r_end;

    // held record, waiting to learn whether it is the last one
    logic        r_held_v;
    logic        r_held_kind;
    logic        r_held_all;
    logic [3:0]  r_held_sub;
    logic [31:0] r_held_before;

    logic        r_strobe;
    logic        r_kind;
    logic        r_all;
    logic [3:0]  r_sub;
    logic [31:0] r_before;
    logic [31:0] r_after;
    logic        r_last;

    logic [4:0]  act_cnt;
    logic [4:0]  act_cnt_m1;
    logic [31:0] cur;
    logic [31:0] first;
    logic        emit;

    assign act_cnt    = (r_count > 5'(DEPTH)) ? 5'(DEPTH) : r_count;
    assign act_cnt_m1 = act_cnt - 5'd1;
    assign cur        = r_tab[r_idx[IW-1:0]];
    assign first      = r_tab[0];

    assign o_status.req_all            = i_all_subresources;
    assign o_status.count_zero         = (act_cnt == 5'd0);
    assign o_status.index_in_range     = ({1'b0, i_subresource_index} < act_cnt);
    assign o_status.cur_eq_want        = (cur == r_want);
    assign o_status.cur_breaks_uniform = (cur == STATE_UNKNOWN) || (cur != first);
    assign o_status.first_eq_want      = (first == r_want);
    assign o_status.at_end             = (r_idx == r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_tab[i] <= STATE_UNKNOWN;
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i_cmd.hold_all && (5'(i) < act_cnt)) begin
                    r_tab[i] <= r_want;
                end else if (i_cmd.hold_entry && (r_idx[IW-1:0] == IW'(i))) begin
                    r_tab[i] <= r_want;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_want <= i_desired_state;
            r_idx  <= i_all_subresources ? 4'd0 : i_subresource_index;
            r_end  <= i_all_subresources ? act_cnt_m1[3:0] : i_subresource_index;
        end else if (i_cmd.restart) begin
            r_idx <= 4'd0;
        end else if (i_cmd.inc) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
        end else if (i_cmd.load || i_cmd.flush) begin
            r_held_v <= 1'b0;
        end else if (i_cmd.hold_entry || i_cmd.hold_all) begin
            r_held_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_all) begin
            r_held_kind   <= KIND_IMMEDIATE;
            r_held_all    <= 1'b1;
            r_held_sub    <= 4'd0;
            r_held_before <= first;
        end else if (i_cmd.hold_entry) begin
            r_held_kind   <= (cur == STATE_UNKNOWN) ? KIND_PENDING : KIND_IMMEDIATE;
            r_held_all    <= 1'b0;
            r_held_sub    <= r_idx;
            r_held_before <= cur;
        end
    end

    assign emit = r_held_v && (i_cmd.hold_entry || i_cmd.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= r_held_kind;
            r_all    <= r_held_all;
            r_sub    <= r_held_sub;
            r_before <= r_held_before;
            r_after  <= r_want;
            r_last   <= i_cmd.flush;
        end
    end

    assign o_strobe              = r_strobe;
    assign o_record_kind         = r_kind;
    assign o_covers_all          = r_all;
    assign o_barrier_subresource = r_sub;
    assign o_state_before        = r_before;
    assign o_state_after         = r_after;
    assign o_last_record         = r_last;

endmodule

@@ rtl/subresource_state_barrier_tracker_core.sv @@
// Single request: WALK, then FLUSH; any record strobes in the cycle after FLUSH. An
// all-subresources request over the entries in use scans them for uniformity (CHECK),
// walks them (WALK) if any is unknown or differs, and ends in FLUSH unless all match.
// One record per changed entry (one for all if uniform), held so the last is flagged.
// Synchronous active-low reset marks every entry unknown and sets the count to 16.
// Results are strobed for one cycle; the receiver cannot stall.
module subresource_state_barrier_tracker_core #(
    parameter int MAX_SUBRESOURCES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_desired_state,
    input  logic        i_all_subresources,
    input  logic [3:0]  i_subresource_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    output logic        o_strobe,
    output logic        o_record_kind,
    output logic        o_covers_all,
    output logic [3:0]  o_barrier_subresource,
    output logic [31:0] o_state_before,
    output logic [31:0] o_state_after,
    output logic        o_last_record
);
    import ssbt_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ssbt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ssbt_datapath #(
        .MAX_SUBRESOURCES (MAX_SUBRESOURCES)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .i_desired_state       (i_desired_state),
        .i_all_subresources    (i_all_subresources),
        .i_subresource_index   (i_subresource_index),
        .i_cmd                 (cmd),
        .o_status              (status),
        .o_strobe              (o_strobe),
        .o_record_kind         (o_record_kind),
        .o_covers_all          (o_covers_all),
        .o_barrier_subresource (o_barrier_subresource),
        .o_state_before        (o_state_before),
        .o_state_after         (o_state_after),
        .o_last_record         (o_last_record)
    );

    // after the final record the next request cannot produce one straight away
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_record |=> !o_strobe)
        else $error("record strobed right after a final record");

    a_all_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_covers_all |-> o_last_record && (o_barrier_subresource == 4'd0))
        else $error("all-subresources barrier not alone or has an index");

    a_pending_before: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_record_kind == KIND_PENDING) |-> (o_state_before == STATE_UNKNOWN))
        else $error("pending record with a known before-state");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !$past(busy) |-> !o_strobe)
        else $error("record strobed while idle");

endmodule

@@ bench/tb_subresource_state_barrier_tracker_core.sv @@
`timescale 1ns / 1ps

module tb_subresource_state_barrier_tracker_core;
    import ssbt_pkg::*;

    typedef struct {
        logic        kind;
        logic        covers_all;
        logic [3:0]  sub;
        logic [31:0] prior;
        logic [31:0] after;
        logic        last;
    } t_barrier_rec;

    class barrier_scoreboard;
        logic [31:0]  sub_states [SUB_LIMIT];
        logic [4:0]   count_reg;
        t_barrier_rec barrier_q [$];
        int           fails;
        int           requests;
        int           all_requests;
        int           records_seen;
        int           whole_barriers;

        function new();
            for (int i = 0; i < SUB_LIMIT; i++) sub_states[i] = STATE_UNKNOWN;
            count_reg = COUNT_RESET;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            fails++;
        endtask

        function void set_count(logic [4:0] value);
            count_reg = value;
        endfunction

        function int unsigned in_use();
            return (count_reg > SUB_LIMIT) ? SUB_LIMIT : count_reg;
        endfunction

        function t_barrier_rec mk_rec(logic kind, logic all, logic [3:0] sub,
                                      logic [31:0] prior, logic [31:0] after, logic last);
            t_barrier_rec r;
            r.kind       = kind;
            r.covers_all = all;
            r.sub        = sub;
            r.prior      = prior;
            r.after      = after;
            r.last       = last;
            return r;
        endfunction

        function void queue_rec(t_barrier_rec r);
            barrier_q = {barrier_q, r};
        endfunction

        function void visit_entry(int idx, logic [31:0] want);
            logic [31:0] cur;
            cur = sub_states[idx];
            if (cur !== want) begin
                if (cur === STATE_UNKNOWN)
                    queue_rec(mk_rec(KIND_PENDING, 1'b0, idx[3:0], STATE_UNKNOWN,
                                     want, 1'b0));
                else
                    queue_rec(mk_rec(KIND_IMMEDIATE, 1'b0, idx[3:0], cur, want, 1'b0));
                sub_states[idx] = want;
            end
        endfunction

        // Work out the barriers one accepted request causes and update the table copy.
        function void note_request(logic [31:0] want, logic all, logic [3:0] idx);
            int unsigned n;
            int          depth_prior;
            logic        uniform;
            logic [31:0] first;
            n           = in_use();
            depth_prior = barrier_q.size();
            requests++;
            if (!all) begin
                if (idx < n) visit_entry(idx, want);
            end else if (n > 0) begin
                all_requests++;
                first   = sub_states[0];
                uniform = (first !== STATE_UNKNOWN);
                for (int i = 0; i < n; i++)
                    if (sub_states[i] !== first) uniform = 1'b0;
                if (uniform) begin
                    if (first !== want) begin
                        queue_rec(mk_rec(KIND_IMMEDIATE, 1'b1, 4'd0, first, want, 1'b0));
                        whole_barriers++;
                        for (int i = 0; i < n; i++) sub_states[i] = want;
                    end
                end else begin
                    for (int i = 0; i < n; i++) visit_entry(i, want);
                end
            end
            if (barrier_q.size() > depth_prior) barrier_q[$].last = 1'b1;
        endfunction

        task check_record(t_barrier_rec got);
            t_barrier_rec exp;
            records_seen++;
            if (barrier_q.size() == 0) begin
                report_mismatch($sformatf("unexpected record kind=%0d all=%0d sub=%0d %h->%h",
                                          got.kind, got.covers_all, got.sub, got.prior,
                                          got.after));
                return;
            end
            exp = barrier_q.pop_front();
            if (got.kind !== exp.kind || got.covers_all !== exp.covers_all ||
                got.sub !== exp.sub || got.prior !== exp.prior ||
                got.after !== exp.after || got.last !== exp.last)
                report_mismatch($sformatf(
                    "got k%0d a%0d s%0d %h->%h l%0d, want k%0d a%0d s%0d %h->%h l%0d",
                    got.kind, got.covers_all, got.sub, got.prior, got.after, got.last,
                    exp.kind, exp.covers_all, exp.sub, exp.prior, exp.after, exp.last));
        endtask

        task check_leftover();
            if (barrier_q.size() != 0)
                report_mismatch($sformatf("%0d expected records never arrived",
                                          barrier_q.size()));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_desired_state = '0;
    logic        i_all_subresources = 1'b0;
    logic [3:0]  i_subresource_index = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;
    logic        o_strobe;
    logic        o_record_kind;
    logic        o_covers_all;
    logic [3:0]  o_barrier_subresource;
    logic [31:0] o_state_before;
    logic [31:0] o_state_after;
    logic        o_last_record;

    barrier_scoreboard sb;
    logic [31:0]       palette [4];

    subresource_state_barrier_tracker_core #(
        .MAX_SUBRESOURCES(16)
    ) uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_desired_state       (i_desired_state),
        .i_all_subresources    (i_all_subresources),
        .i_subresource_index   (i_subresource_index),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .o_strobe              (o_strobe),
        .o_record_kind         (o_record_kind),
        .o_covers_all          (o_covers_all),
        .o_barrier_subresource (o_barrier_subresource),
        .o_state_before        (o_state_before),
        .o_state_after         (o_state_after),
        .o_last_record         (o_last_record)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_record(sb.mk_rec(o_record_kind, o_covers_all, o_barrier_subresource,
                                      o_state_before, o_state_after, o_last_record));
    end

    // Start stays high when the next request follows straight on.
    task automatic send_request(input logic [31:0] want, input logic all,
                                input logic [3:0] idx, input int idle_pct);
        int gap;
        gap                 = 0;
        start               <= 1'b1;
        i_desired_state     <= want;
        i_all_subresources  <= all;
        i_subresource_index <= idx;
        do @(posedge i_clk); while (busy);
        sb.note_request(want, all, idx);
        if ($urandom_range(0, 99) < idle_pct)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every expected record is in, then let any silent request finish.
    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.barrier_q.size() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [4:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_count(value);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_state();
        if ($urandom_range(0, 99) < 70) return palette[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    initial begin
        #5_000_000;
        $display("timeout: run did not finish");
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int          idle_pct;
        logic [4:0]  cnt;
        logic        all;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: count 16 from reset
        send_request(32'h0000_0000, 1'b0, 4'd0, 0);   // pending, entry unknown
        send_request(32'h0000_0000, 1'b0, 4'd0, 0);   // already in state
        send_request(32'h0000_0001, 1'b0, 4'd0, 0);   // immediate
        send_request(32'h0000_0005, 1'b1, 4'd0, 0);   // mixed walk
        send_request(32'h0000_0005, 1'b1, 4'd9, 0);   // uniform, already there
        send_request(32'h8000_0000, 1'b1, 4'd0, 0);   // whole-resource barrier
        send_request(STATE_UNKNOWN, 1'b0, 4'd15, 0);  // back to unknown
        send_request(STATE_UNKNOWN, 1'b1, 4'd0, 0);
        send_request(STATE_UNKNOWN, 1'b0, 4'd3, 0);   // unknown to unknown: silent
        send_request(32'h0000_0000, 1'b1, 4'd0, 0);   // all pending
        wait_idle();
        write_count(5'd4);
        send_request(32'h0000_0007, 1'b0, 4'd4, 0);   // index out of range
        send_request(32'h0000_0007, 1'b0, 4'd15, 0);
        send_request(32'h0000_0007, 1'b0, 4'd3, 0);
        send_request(32'h0000_0009, 1'b1, 4'd0, 0);
        send_request(32'h0000_0009, 1'b1, 4'd0, 0);
        send_request(32'h0000_0000, 1'b1, 4'd0, 0);
        wait_idle();
        write_count(5'd0);                            // zero count
        send_request(32'h0000_0003, 1'b1, 4'd0, 0);
        send_request(32'h0000_0003, 1'b0, 4'd0, 0);
        wait_idle();
        write_count(5'd31);                           // clamps to 16
        send_request(32'hFFFF_FFFE, 1'b1, 4'd0, 0);
        send_request(32'h5555_5555, 1'b0, 4'd7, 0);
        send_request(32'hAAAA_AAAA, 1'b1, 4'd0, 0);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin cnt = 5'd16; idle_pct = 0; end
                1: begin cnt = 5'd1; idle_pct = 48; end
                2: begin cnt = 5'($urandom_range(2, 15)); idle_pct = 0; end
                3: begin cnt = 5'd31; idle_pct = 6; end
                default: begin cnt = 5'($urandom_range(1, 16)); idle_pct = 48; end
            endcase
            write_count(cnt);
            palette[0] = STATE_UNKNOWN;
            palette[1] = $urandom();
            palette[2] = $urandom();
            palette[3] = $urandom_range(0, 3);
            for (int k = 0; k < 66; k++) begin
                all = ($urandom_range(0, 99) < 35);
                send_request(pick_state(), all, 4'($urandom_range(0, 15)), idle_pct);
                if ($urandom_range(0, 59) == 0) wait_idle();
            end
            wait_idle();
        end

        sb.check_leftover();
        $display("covered %0d requests (%0d over all subresources), %0d records checked",
                 sb.requests, sb.all_requests, sb.records_seen);
        $display("whole-resource barriers: %0d; counts 0, 1, 4, 16, 31 and random",
                 sb.whole_barriers);
        if (sb.fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
